// File: rtl/lts_pkg.sv
package lts_pkg;

  // field and state widths
  localparam int COUNT_BITS    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int SUM_BITS      = 64;
  localparam int TIME_BITS     = 31;
  localparam int AVG_BITS      = 35;
  localparam int RESP_BITS     = 32;
  localparam int CMD_BITS      = 3;
  localparam int CNT_OUT_BITS  = 32;
  localparam int FRAC_OUT_BITS = 17;

  // derived divider widths
  localparam int RECV_BITS   = COUNT_BITS + 1;
  localparam int REM_BITS    = COUNT_BITS + 2;
  localparam int SHIFT_BITS  = SUM_BITS + 4;
  localparam int STEP_BITS   = $clog2(SHIFT_BITS + 1);
  localparam int FRAC_W      = FRACTION_BITS + 1;

  localparam logic [AVG_BITS-1:0] AVG_MAX = {AVG_BITS{1'b1}};

  // event codes
  typedef enum logic [CMD_BITS-1:0] {
    CMD_SENT     = CMD_BITS'(0),
    CMD_MATCH    = CMD_BITS'(1),
    CMD_MISMATCH = CMD_BITS'(2),
    CMD_TIMEOUT  = CMD_BITS'(3),
    CMD_CLEAR    = CMD_BITS'(4)
  } lts_event_t;

  // divisions run in this order
  typedef enum logic [1:0] {
    OP_AVG     = 2'd0,
    OP_LOSS    = 2'd1,
    OP_CORRECT = 2'd2,
    OP_SUCCESS = 2'd3
  } lts_op_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WAIT  = 4'b0100,
    S_LOAD  = 4'b1000
  } lts_state_t;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    div_start;
    logic    capture;
    logic    load_out;
    lts_op_t op;
  } lts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
  } lts_stat_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

endpackage

// File: rtl/link_test_statistics.sv
// link test statistics
// input channel: in_valid / in_stall carry one event word (command, resp_time);
//   command is sent, matched reply, mismatched reply, timeout or clear.
// output channel: out_valid / out_stall carry one statistics word per event:
//   saturating counts, min / max / average response time and three Q1.16 rates.
// an event is taken when in_valid is high and in_stall is low; the counters
//   are updated at that edge, then a shared restoring divider, one quotient
//   bit per cycle, computes the average (68 steps) and loss, correct and
//   success rates (16 steps each).
// events are handled one at a time.
// the next event is taken as soon as the result sits in the output register,
//   while that result still waits; if the receiver stalls and a second
//   result is ready, that second result waits in the datapath and in_stall
//   stays high until the output register frees.
// reset (rst, synchronous) clears all statistics and drops out_valid; the
//   clear command does the same to the statistics and reports zeros.
module link_test_statistics (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [lts_pkg::CMD_BITS-1:0]         command,
  input  logic signed [lts_pkg::RESP_BITS-1:0] resp_time,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [lts_pkg::CNT_OUT_BITS-1:0]     sent_total,
  output logic [lts_pkg::CNT_OUT_BITS-1:0]     match_total,
  output logic [lts_pkg::CNT_OUT_BITS-1:0]     mismatch_total,
  output logic [lts_pkg::CNT_OUT_BITS-1:0]     timeout_total,
  output logic [lts_pkg::TIME_BITS-1:0]        min_time,
  output logic [lts_pkg::TIME_BITS-1:0]        max_time,
  output logic [lts_pkg::AVG_BITS-1:0]         avg_time,
  output logic [lts_pkg::FRAC_OUT_BITS-1:0]    loss_fraction,
  output logic [lts_pkg::FRAC_OUT_BITS-1:0]    correct_fraction,
  output logic                                 correct_valid,
  output logic [lts_pkg::FRAC_OUT_BITS-1:0]    success_fraction
);
  import lts_pkg::*;

  lts_cmd_t  cmd;
  lts_stat_t stat;

  lts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lts_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .command          (command),
    .resp_time        (resp_time),
    .sent_total       (sent_total),
    .match_total      (match_total),
    .mismatch_total   (mismatch_total),
    .timeout_total    (timeout_total),
    .min_time         (min_time),
    .max_time         (max_time),
    .avg_time         (avg_time),
    .loss_fraction    (loss_fraction),
    .correct_fraction (correct_fraction),
    .correct_valid    (correct_valid),
    .success_fraction (success_fraction)
  );

endmodule

// File: rtl/lts_div.sv
module lts_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [lts_pkg::REM_BITS-1:0]   rem_init,
  input  logic [lts_pkg::RECV_BITS-1:0]  den_in,
  input  logic [lts_pkg::SHIFT_BITS-1:0] dividend,
  input  logic [lts_pkg::STEP_BITS-1:0]  steps,
  output logic                           busy,
  output logic [lts_pkg::AVG_BITS-1:0]   quot,
  output logic                           ovf
);
  import lts_pkg::*;

  logic [REM_BITS-1:0]   rem;
  logic [RECV_BITS-1:0]  den;
  logic [SHIFT_BITS-1:0] sh;
  logic [STEP_BITS-1:0]  cnt;
  logic [REM_BITS-1:0]   trial;
  logic [REM_BITS-1:0]   diff;
  logic                  fits;

  // one restoring step per cycle
  assign trial = {rem[REM_BITS-2:0], sh[SHIFT_BITS-1]};
  assign fits  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  // busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == STEP_BITS'(1)) begin
      busy <= 1'b0;
    end
  end

  // remainder, dividend bits and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rem_init;
      den  <= den_in;
      sh   <= dividend;
      cnt  <= steps;
      quot <= '0;
      ovf  <= 1'b0;
    end else if (busy) begin
      rem  <= fits ? diff : trial;
      sh   <= {sh[SHIFT_BITS-2:0], 1'b0};
      quot <= {quot[AVG_BITS-2:0], fits};
      ovf  <= ovf | quot[AVG_BITS-1];
      cnt  <= cnt - STEP_BITS'(1);
    end
  end

endmodule

// File: rtl/lts_datapath.sv
module lts_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lts_pkg::lts_cmd_t                     cmd,
  output lts_pkg::lts_stat_t                    stat,
  input  logic [lts_pkg::CMD_BITS-1:0]          command,
  input  logic signed [lts_pkg::RESP_BITS-1:0]  resp_time,
  output logic [lts_pkg::CNT_OUT_BITS-1:0]      sent_total,
  output logic [lts_pkg::CNT_OUT_BITS-1:0]      match_total,
  output logic [lts_pkg::CNT_OUT_BITS-1:0]      mismatch_total,
  output logic [lts_pkg::CNT_OUT_BITS-1:0]      timeout_total,
  output logic [lts_pkg::TIME_BITS-1:0]         min_time,
  output logic [lts_pkg::TIME_BITS-1:0]         max_time,
  output logic [lts_pkg::AVG_BITS-1:0]          avg_time,
  output logic [lts_pkg::FRAC_OUT_BITS-1:0]     loss_fraction,
  output logic [lts_pkg::FRAC_OUT_BITS-1:0]     correct_fraction,
  output logic                                  correct_valid,
  output logic [lts_pkg::FRAC_OUT_BITS-1:0]     success_fraction
);
  import lts_pkg::*;

  logic [COUNT_BITS-1:0] sent_count;
  logic [COUNT_BITS-1:0] match_count;
  logic [COUNT_BITS-1:0] mismatch_count;
  logic [COUNT_BITS-1:0] timeout_count;
  logic [SUM_BITS-1:0]   time_sum;
  logic [TIME_BITS-1:0]  time_min;
  logic [TIME_BITS-1:0]  time_max;

  logic [TIME_BITS-1:0]  t_clamp;
  logic [SUM_BITS:0]     sum_wide;
  logic [SUM_BITS-1:0]   sum_next;
  logic [RECV_BITS-1:0]  recv;

  logic [REM_BITS-1:0]   div_rem;
  logic [RECV_BITS-1:0]  div_den;
  logic [SHIFT_BITS-1:0] div_dividend;
  logic [STEP_BITS-1:0]  div_steps;
  logic                  div_busy;
  logic [AVG_BITS-1:0]   div_quot;
  logic                  div_ovf;

  logic [AVG_BITS-1:0]   avg_r;
  logic [FRAC_W-1:0]     loss_r;
  logic [FRAC_W-1:0]     correct_r;
  logic [FRAC_W-1:0]     success_r;

  // fraction with zero divisor and saturation at one
  function automatic logic [FRAC_W-1:0] frac_fix(
    input logic [COUNT_BITS-1:0] num,
    input logic [RECV_BITS-1:0]  den,
    input logic [AVG_BITS-1:0]   q
  );
    if (den == '0) begin
      return '0;
    end else if ({1'b0, num} >= den) begin
      return FRAC_W'(1) << FRACTION_BITS;
    end else begin
      return q[FRAC_W-1:0];
    end
  endfunction

  // clamp negative times, saturating sum
  assign t_clamp  = resp_time[RESP_BITS-1] ? '0 : resp_time[TIME_BITS-1:0];
  assign sum_wide = {1'b0, time_sum} + (SUM_BITS+1)'(t_clamp);
  assign sum_next = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];
  assign recv     = {1'b0, match_count} + {1'b0, mismatch_count};

  // statistics update on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      sent_count     <= '0;
      match_count    <= '0;
      mismatch_count <= '0;
      timeout_count  <= '0;
      time_sum       <= '0;
      time_min       <= '0;
      time_max       <= '0;
    end else if (cmd.accept) begin
      case (command)
        CMD_SENT: begin
          sent_count <= sat_inc(sent_count);
        end
        CMD_MATCH: begin
          match_count <= sat_inc(match_count);
          time_sum    <= sum_next;
          if (match_count == '0 || t_clamp < time_min) begin
            time_min <= t_clamp;
          end
          if (t_clamp > time_max) begin
            time_max <= t_clamp;
          end
        end
        CMD_MISMATCH: begin
          mismatch_count <= sat_inc(mismatch_count);
        end
        CMD_TIMEOUT: begin
          timeout_count <= sat_inc(timeout_count);
        end
        CMD_CLEAR: begin
          sent_count     <= '0;
          match_count    <= '0;
          mismatch_count <= '0;
          timeout_count  <= '0;
          time_sum       <= '0;
          time_min       <= '0;
          time_max       <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // divider operands per division
  always_comb begin
    div_rem      = '0;
    div_den      = {1'b0, sent_count};
    div_dividend = '0;
    div_steps    = STEP_BITS'(FRACTION_BITS);
    case (cmd.op)
      OP_AVG: begin
        div_den      = {1'b0, match_count};
        div_dividend = {time_sum, 4'b0000};
        div_steps    = STEP_BITS'(SHIFT_BITS);
      end
      OP_LOSS: begin
        div_rem = REM_BITS'(timeout_count);
      end
      OP_CORRECT: begin
        div_rem = REM_BITS'(match_count);
        div_den = recv;
      end
      OP_SUCCESS: begin
        div_rem = REM_BITS'(match_count);
      end
      default: begin
      end
    endcase
  end

  lts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .rem_init (div_rem),
    .den_in   (div_den),
    .dividend (div_dividend),
    .steps    (div_steps),
    .busy     (div_busy),
    .quot     (div_quot),
    .ovf      (div_ovf)
  );

  assign stat.div_busy = div_busy;

  // capture quotients with special cases
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      case (cmd.op)
        OP_AVG: begin
          avg_r <= (match_count == '0) ? '0 : (div_ovf ? AVG_MAX : div_quot);
        end
        OP_LOSS: begin
          loss_r <= frac_fix(timeout_count, {1'b0, sent_count}, div_quot);
        end
        OP_CORRECT: begin
          correct_r <= frac_fix(match_count, recv, div_quot);
        end
        OP_SUCCESS: begin
          success_r <= frac_fix(match_count, {1'b0, sent_count}, div_quot);
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sent_total       <= CNT_OUT_BITS'(sent_count);
      match_total      <= CNT_OUT_BITS'(match_count);
      mismatch_total   <= CNT_OUT_BITS'(mismatch_count);
      timeout_total    <= CNT_OUT_BITS'(timeout_count);
      min_time         <= time_min;
      max_time         <= time_max;
      avg_time         <= avg_r;
      loss_fraction    <= FRAC_OUT_BITS'(loss_r);
      correct_fraction <= FRAC_OUT_BITS'(correct_r);
      correct_valid    <= recv != '0;
      success_fraction <= FRAC_OUT_BITS'(success_r);
    end
  end

endmodule

// File: rtl/lts_ctrl.sv
module lts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  lts_pkg::lts_stat_t stat,
  output lts_pkg::lts_cmd_t  cmd
);
  import lts_pkg::*;

  lts_state_t state;
  lts_state_t state_next;
  lts_op_t    op;
  lts_op_t    op_next;

  assign in_stall = state != S_IDLE;

  // sequencing of update, four divisions and output load
  always_comb begin
    state_next    = state;
    op_next       = op;
    cmd.accept    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.capture   = 1'b0;
    cmd.load_out  = 1'b0;
    cmd.op        = op;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          op_next    = OP_AVG;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (!stat.div_busy) begin
          cmd.capture = 1'b1;
          if (op == OP_SUCCESS) begin
            state_next = S_LOAD;
          end else begin
            op_next    = lts_op_t'(op + 2'd1);
            state_next = S_START;
          end
        end
      end
      S_LOAD: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_AVG;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/lts_checker.sv
module lts_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic [lts_pkg::CMD_BITS-1:0]         command,
  input logic signed [lts_pkg::RESP_BITS-1:0] resp_time,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [lts_pkg::CNT_OUT_BITS-1:0]     sent_total,
  input logic [lts_pkg::CNT_OUT_BITS-1:0]     match_total,
  input logic [lts_pkg::CNT_OUT_BITS-1:0]     mismatch_total,
  input logic [lts_pkg::CNT_OUT_BITS-1:0]     timeout_total,
  input logic [lts_pkg::TIME_BITS-1:0]        min_time,
  input logic [lts_pkg::TIME_BITS-1:0]        max_time,
  input logic [lts_pkg::AVG_BITS-1:0]         avg_time,
  input logic [lts_pkg::FRAC_OUT_BITS-1:0]    loss_fraction,
  input logic [lts_pkg::FRAC_OUT_BITS-1:0]    correct_fraction,
  input logic                                 correct_valid,
  input logic [lts_pkg::FRAC_OUT_BITS-1:0]    success_fraction
);

  // a stalled word stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a stalled word keeps its statistics
  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(sent_total) && $stable(avg_time)
      && $stable(success_fraction))
    else $error("output word changed while stalled");

  // correct flag follows the reply counts
  a_correct_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> correct_valid == ((match_total != '0) || (mismatch_total != '0)))
    else $error("correct_valid disagrees with reply counts");

  // no sends gives zero rates over sends
  a_no_sent: assert property (@(posedge clk) disable iff (rst)
    out_valid && sent_total == '0 |-> loss_fraction == '0 && success_fraction == '0)
    else $error("nonzero rate with no frames sent");

  // no matches gives zero times
  a_no_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && match_total == '0 |-> avg_time == '0 && min_time == '0
      && max_time == '0)
    else $error("nonzero time with no matches");

endmodule

bind link_test_statistics lts_checker u_lts_checker (.*);
